// ===== hw/rtl/euv_pkg.sv =====
// euv_pkg: shared types, constants and the cordic angle table
// for the equirectangular uv triangle block; depends on nothing
package euv_pkg;

  // datapath width of the cordic vector registers
  localparam int WB = 40;
  // angle width, turns scaled by 2^32, signed
  localparam int AB = 34;
  // coordinates are scaled to this many bits
  localparam int WorkBits = 34;
  localparam int TabLen = 24;
  localparam logic [23:0] KINV_Q24 = 24'd10187457;
  localparam logic signed [AB-1:0] HALF_TURN = 34'sh080000000;
  localparam logic signed [AB-1:0] QUARTER_TURN = 34'sh040000000;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_SEAM = 2'd0,
    CFG_LOW  = 2'd1
  } cfg_idx_t;

  // special-case control for one atan2 evaluation
  typedef struct packed {
    logic                 fixed;
    logic signed [AB-1:0] fixed_val;
    logic signed [AB-1:0] base;
  } ang_ctl_t;

  // round(atan(2^-i) / 2pi * 2^32)
  function automatic logic signed [AB-1:0] atan_turns(input int i);
    logic signed [AB-1:0] t;
    unique case (i)
      0:  t = 34'sd536870912;
      1:  t = 34'sd316933406;
      2:  t = 34'sd167458907;
      3:  t = 34'sd85004756;
      4:  t = 34'sd42667331;
      5:  t = 34'sd21354465;
      6:  t = 34'sd10679838;
      7:  t = 34'sd5340245;
      8:  t = 34'sd2670163;
      9:  t = 34'sd1335087;
      10: t = 34'sd667544;
      11: t = 34'sd333772;
      12: t = 34'sd166886;
      13: t = 34'sd83443;
      14: t = 34'sd41722;
      15: t = 34'sd20861;
      16: t = 34'sd10430;
      17: t = 34'sd5215;
      18: t = 34'sd2608;
      19: t = 34'sd1304;
      20: t = 34'sd652;
      21: t = 34'sd326;
      22: t = 34'sd163;
      23: t = 34'sd81;
      default: t = '0;
    endcase
    return t;
  endfunction

  // atan2 prep: special axes, half-plane fold and base angle
  function automatic ang_ctl_t ang_prep(input logic signed [WB-1:0] px,
                                        input logic signed [WB-1:0] py);
    ang_ctl_t c;
    c.fixed = 1'b0;
    c.fixed_val = '0;
    c.base = '0;
    if (py == '0) begin
      c.fixed = 1'b1;
      c.fixed_val = px[WB-1] ? HALF_TURN : '0;
    end else if (px == '0) begin
      c.fixed = 1'b1;
      c.fixed_val = py[WB-1] ? -QUARTER_TURN : QUARTER_TURN;
    end
    if (px[WB-1]) begin
      c.base = py[WB-1] ? -HALF_TURN : HALF_TURN;
    end
    return c;
  endfunction

  // final angle: special value or clamped base plus cordic sum
  function automatic logic signed [AB-1:0] ang_final(input ang_ctl_t c,
                                                     input logic signed [AB-1:0] acc);
    logic signed [AB-1:0] a;
    a = c.base + acc;
    if (a > HALF_TURN) begin
      a = HALF_TURN;
    end
    if (a < -HALF_TURN) begin
      a = -HALF_TURN;
    end
    return c.fixed ? c.fixed_val : a;
  endfunction

endpackage

// ===== hw/rtl/euv_cordic_cell.sv =====
// euv_cordic_cell: one registered cordic vectoring iteration
// depends on euv_pkg for widths and the angle table
module euv_cordic_cell #(
  parameter int STAGE = 0
) (
  input  logic                          clk,
  input  logic                          adv,
  input  logic signed [euv_pkg::WB-1:0] x_i,
  input  logic signed [euv_pkg::WB-1:0] y_i,
  input  logic signed [euv_pkg::AB-1:0] a_i,
  output logic signed [euv_pkg::WB-1:0] x_o,
  output logic signed [euv_pkg::WB-1:0] y_o,
  output logic signed [euv_pkg::AB-1:0] a_o
);

  logic signed [euv_pkg::WB-1:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [euv_pkg::AB-1:0] a_r, a_nxt;
  logic signed [euv_pkg::WB-1:0] dx, dy;

  // rotate toward y = 0, floor shifts
  always_comb begin
    dx = y_i >>> STAGE;
    dy = x_i >>> STAGE;
    if (!y_i[euv_pkg::WB-1]) begin
      x_nxt = x_i + dx;
      y_nxt = y_i - dy;
      a_nxt = a_i + euv_pkg::atan_turns(STAGE);
    end else begin
      x_nxt = x_i - dx;
      y_nxt = y_i + dy;
      a_nxt = a_i - euv_pkg::atan_turns(STAGE);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      a_r <= a_nxt;
    end
  end

  assign x_o = x_r;
  assign y_o = y_r;
  assign a_o = a_r;

endmodule

// ===== hw/rtl/euv_vertex.sv =====
// euv_vertex: uv pipeline for one vertex, three cordic chains and a magnitude scale
// depends on euv_pkg and euv_cordic_cell
module euv_vertex #(
  parameter int COORD_BITS    = 16,
  parameter int FRACTION_BITS = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  logic                          clk,
  input  logic                          adv,
  input  logic signed [COORD_BITS-1:0]  x_i,
  input  logic signed [COORD_BITS-1:0]  y_i,
  input  logic signed [COORD_BITS-1:0]  z_i,
  output logic [FRACTION_BITS+1:0]      u_o,
  output logic [FRACTION_BITS:0]        v_o,
  output logic                          zero_o
);

  localparam int WB = euv_pkg::WB;
  localparam int AB = euv_pkg::AB;
  localparam int S  = CORDIC_STAGES;
  localparam int SH = euv_pkg::WorkBits - COORD_BITS;
  localparam int FS = 32 - FRACTION_BITS;
  localparam int UW = FRACTION_BITS + 2;
  localparam int VW = FRACTION_BITS + 1;

  // angle in [0, 2^32] to output fraction, half step rounding
  function automatic logic [VW-1:0] to_frac(input logic signed [AB-1:0] full);
    logic signed [AB-1:0] t;
    t = (full + (AB'(1) <<< (FS - 1))) >>> FS;
    return t[VW-1:0];
  endfunction

  // prep stage
  logic signed [WB-1:0] sx, sy, sz;
  euv_pkg::ang_ctl_t    uctl_nxt;
  logic signed [WB-1:0] p_mx_r, p_mz_r, p_ux_r, p_uz_r;

  logic signed [WB-1:0] sb_y_r [0:S];
  euv_pkg::ang_ctl_t    sb_uctl_r [0:S];
  logic                 sb_zero_r [0:S];

  always_comb begin
    sx = WB'(x_i) <<< SH;
    sy = WB'(y_i) <<< SH;
    sz = WB'(z_i) <<< SH;
    uctl_nxt = euv_pkg::ang_prep(sx, sz);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_mx_r       <= sx[WB-1] ? -sx : sx;
      p_mz_r       <= sz;
      p_ux_r       <= sx[WB-1] ? -sx : sx;
      p_uz_r       <= sx[WB-1] ? -sz : sz;
      sb_y_r[0]    <= sy;
      sb_uctl_r[0] <= uctl_nxt;
      sb_zero_r[0] <= (x_i == '0) && (y_i == '0) && (z_i == '0);
    end
  end

  // u chain and magnitude chain side by side
  logic signed [WB-1:0] ux [0:S];
  logic signed [WB-1:0] uz [0:S];
  logic signed [AB-1:0] ua [0:S];
  logic signed [WB-1:0] mx [0:S];
  logic signed [WB-1:0] mz [0:S];
  logic signed [AB-1:0] ma [0:S];

  assign ux[0] = p_ux_r;
  assign uz[0] = p_uz_r;
  assign ua[0] = '0;
  assign mx[0] = p_mx_r;
  assign mz[0] = p_mz_r;
  assign ma[0] = '0;

  for (genvar k = 0; k < S; k++) begin : g_first
    euv_cordic_cell #(.STAGE(k)) u_ucell (
      .clk(clk), .adv(adv),
      .x_i(ux[k]), .y_i(uz[k]), .a_i(ua[k]),
      .x_o(ux[k+1]), .y_o(uz[k+1]), .a_o(ua[k+1])
    );
    euv_cordic_cell #(.STAGE(k)) u_mcell (
      .clk(clk), .adv(adv),
      .x_i(mx[k]), .y_i(mz[k]), .a_i(ma[k]),
      .x_o(mx[k+1]), .y_o(mz[k+1]), .a_o(ma[k+1])
    );
    always_ff @(posedge clk) begin
      if (adv) begin
        sb_y_r[k+1]    <= sb_y_r[k];
        sb_uctl_r[k+1] <= sb_uctl_r[k];
        sb_zero_r[k+1] <= sb_zero_r[k];
      end
    end
  end

  // split magnitude scale: partial products, then sum
  logic [37:0]          mxu;
  logic [43:0]          m1_lo_r;
  logic [41:0]          m1_hi_r;
  logic [VW-1:0]        m1_u_r, m2_u_r, vp_u_r;
  logic signed [WB-1:0] m1_y_r, m2_y_r, m2_r_r;
  logic                 m1_zero_r, m2_zero_r, vp_zero_r;
  logic [61:0]          msum;

  assign mxu  = mx[S][37:0];
  assign msum = {m1_hi_r, 20'd0} + 62'(m1_lo_r) + 62'd8388608;

  always_ff @(posedge clk) begin
    if (adv) begin
      m1_lo_r   <= 44'(mxu[19:0]) * 44'(euv_pkg::KINV_Q24);
      m1_hi_r   <= 42'(mxu[37:20]) * 42'(euv_pkg::KINV_Q24);
      m1_u_r    <= to_frac(euv_pkg::ang_final(sb_uctl_r[S], ua[S]) + euv_pkg::HALF_TURN);
      m1_y_r    <= sb_y_r[S];
      m1_zero_r <= sb_zero_r[S];
      m2_r_r    <= WB'(msum[61:24]);
      m2_u_r    <= m1_u_r;
      m2_y_r    <= m1_y_r;
      m2_zero_r <= m1_zero_r;
    end
  end

  // polar angle prep: atan2(r, y)
  logic signed [WB-1:0] vp_x_r, vp_y_r;
  logic [VW-1:0]        sv_u_r [0:S];
  euv_pkg::ang_ctl_t    sv_ctl_r [0:S];
  logic                 sv_zero_r [0:S];

  always_ff @(posedge clk) begin
    if (adv) begin
      vp_x_r       <= m2_y_r[WB-1] ? -m2_y_r : m2_y_r;
      vp_y_r       <= m2_y_r[WB-1] ? -m2_r_r : m2_r_r;
      sv_ctl_r[0]  <= euv_pkg::ang_prep(m2_y_r, m2_r_r);
      sv_u_r[0]    <= m2_u_r;
      sv_zero_r[0] <= m2_zero_r;
    end
  end

  assign vp_u_r    = sv_u_r[0];
  assign vp_zero_r = sv_zero_r[0];

  logic signed [WB-1:0] vx [0:S];
  logic signed [WB-1:0] vy [0:S];
  logic signed [AB-1:0] va [0:S];

  assign vx[0] = vp_x_r;
  assign vy[0] = vp_y_r;
  assign va[0] = '0;

  for (genvar k = 0; k < S; k++) begin : g_second
    euv_cordic_cell #(.STAGE(k)) u_vcell (
      .clk(clk), .adv(adv),
      .x_i(vx[k]), .y_i(vy[k]), .a_i(va[k]),
      .x_o(vx[k+1]), .y_o(vy[k+1]), .a_o(va[k+1])
    );
    always_ff @(posedge clk) begin
      if (adv) begin
        sv_u_r[k+1]    <= (k == 0) ? vp_u_r : sv_u_r[k];
        sv_ctl_r[k+1]  <= sv_ctl_r[k];
        sv_zero_r[k+1] <= (k == 0) ? vp_zero_r : sv_zero_r[k];
      end
    end
  end

  // final: clamp polar angle at zero, scale to fraction
  logic signed [AB-1:0] vang;
  logic [UW-1:0]        u_r;
  logic [VW-1:0]        v_r;
  logic                 zero_r;

  always_comb begin
    vang = euv_pkg::ang_final(sv_ctl_r[S], va[S]);
    if (vang[AB-1]) begin
      vang = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      u_r    <= UW'(sv_u_r[S]);
      v_r    <= to_frac(vang <<< 1);
      zero_r <= sv_zero_r[S];
    end
  end

  assign u_o    = u_r;
  assign v_o    = v_r;
  assign zero_o = zero_r;

endmodule

// ===== hw/rtl/equirect_uv_triangle.sv =====
// equirect_uv_triangle: top level, three vertex pipelines, seam repair, output register
// depends on euv_pkg and euv_vertex
//
//  channel | direction | handshake           | payload
//  in_     | input     | in_valid / in_stall | in_ax .. in_cz
//  out_    | output    | out_valid/out_stall | out_u_a .. out_degenerate
//  cfg_    | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// one triangle per cycle while the output register is not stalled; depth set by the two
// dependent cordic chains (azimuth/magnitude, then polar angle) plus scale stages
// the whole pipeline moves when the output register is empty or being taken
// synchronous active-low reset clears valid bits and restores the thresholds
// cfg_ready is always high
module equirect_uv_triangle #(
  parameter int COORD_BITS    = 16,
  parameter int FRACTION_BITS = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COORD_BITS-1:0] in_ax,
  input  logic signed [COORD_BITS-1:0] in_ay,
  input  logic signed [COORD_BITS-1:0] in_az,
  input  logic signed [COORD_BITS-1:0] in_bx,
  input  logic signed [COORD_BITS-1:0] in_by_coord,
  input  logic signed [COORD_BITS-1:0] in_bz,
  input  logic signed [COORD_BITS-1:0] in_cx,
  input  logic signed [COORD_BITS-1:0] in_cy,
  input  logic signed [COORD_BITS-1:0] in_cz,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [FRACTION_BITS+1:0]     out_u_a,
  output logic [FRACTION_BITS:0]       out_v_a,
  output logic [FRACTION_BITS+1:0]     out_u_b,
  output logic [FRACTION_BITS:0]       out_v_b,
  output logic [FRACTION_BITS+1:0]     out_u_c,
  output logic [FRACTION_BITS:0]       out_v_c,
  output logic                         out_degenerate,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [1:0]                   cfg_index,
  input  logic [FRACTION_BITS:0]       cfg_data
);

  localparam int UW  = FRACTION_BITS + 2;
  localparam int VW  = FRACTION_BITS + 1;
  localparam int LAT = 2 * CORDIC_STAGES + 5;
  localparam logic [VW-1:0] SeamReset = VW'(((7 << FRACTION_BITS) + 5) / 10);
  localparam logic [VW-1:0] LowReset  = VW'(((3 << FRACTION_BITS) + 5) / 10);
  localparam logic [UW-1:0] One = UW'(1) << FRACTION_BITS;

  logic adv;
  assign adv       = !(out_valid && out_stall);
  assign in_stall  = !adv;
  assign cfg_ready = 1'b1;

  // configuration registers
  logic [VW-1:0] seam_thr_r, low_thr_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seam_thr_r <= SeamReset;
      low_thr_r  <= LowReset;
    end else if (cfg_valid) begin
      if (cfg_index == euv_pkg::CFG_SEAM) begin
        seam_thr_r <= cfg_data;
      end else if (cfg_index == euv_pkg::CFG_LOW) begin
        low_thr_r <= cfg_data;
      end
    end
  end

  // valid tracking along the pipeline
  logic [LAT-1:0] vld_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  // vertex pipelines
  logic [UW-1:0] u0, u1, u2;
  logic [VW-1:0] v0, v1, v2;
  logic          z0, z1, z2;

  euv_vertex #(.COORD_BITS(COORD_BITS), .FRACTION_BITS(FRACTION_BITS),
               .CORDIC_STAGES(CORDIC_STAGES)) u_vtx_a (
    .clk(clk), .adv(adv), .x_i(in_ax), .y_i(in_ay), .z_i(in_az),
    .u_o(u0), .v_o(v0), .zero_o(z0)
  );
  euv_vertex #(.COORD_BITS(COORD_BITS), .FRACTION_BITS(FRACTION_BITS),
               .CORDIC_STAGES(CORDIC_STAGES)) u_vtx_b (
    .clk(clk), .adv(adv), .x_i(in_bx), .y_i(in_by_coord), .z_i(in_bz),
    .u_o(u1), .v_o(v1), .zero_o(z1)
  );
  euv_vertex #(.COORD_BITS(COORD_BITS), .FRACTION_BITS(FRACTION_BITS),
               .CORDIC_STAGES(CORDIC_STAGES)) u_vtx_c (
    .clk(clk), .adv(adv), .x_i(in_cx), .y_i(in_cy), .z_i(in_cz),
    .u_o(u2), .v_o(v2), .zero_o(z2)
  );

  // seam test on one pair: which side gains a unit
  function automatic logic [1:0] seam_pick(input logic [UW-1:0] f, input logic [UW-1:0] s,
                                           input logic [VW-1:0] thr, input logic [VW-1:0] low);
    logic [UW-1:0] d;
    logic [1:0]    p;
    d = (f > s) ? (f - s) : (s - f);
    p = 2'b00;
    if (32'(d) > 32'(thr)) begin
      p = (32'(f) < 32'(low)) ? 2'b01 : 2'b10;
    end
    return p;
  endfunction

  // seam repair in pair order, each on repaired values
  logic [UW-1:0] s0, s1, s2;
  logic [1:0]    pk;
  logic          degen;
  always_comb begin
    s0 = u0;
    s1 = u1;
    s2 = u2;
    pk = seam_pick(s0, s1, seam_thr_r, low_thr_r);
    if (pk[0]) s0 = s0 + One;
    if (pk[1]) s1 = s1 + One;
    pk = seam_pick(s0, s2, seam_thr_r, low_thr_r);
    if (pk[0]) s0 = s0 + One;
    if (pk[1]) s2 = s2 + One;
    pk = seam_pick(s1, s2, seam_thr_r, low_thr_r);
    if (pk[0]) s1 = s1 + One;
    if (pk[1]) s2 = s2 + One;
    degen = z0 || z1 || z2;
  end

  // output register
  logic ovld_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovld_r <= 1'b0;
    end else if (adv) begin
      ovld_r <= vld_r[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_u_a        <= degen ? '0 : s0;
      out_u_b        <= degen ? '0 : s1;
      out_u_c        <= degen ? '0 : s2;
      out_v_a        <= degen ? '0 : v0;
      out_v_b        <= degen ? '0 : v1;
      out_v_c        <= degen ? '0 : v2;
      out_degenerate <= degen;
    end
  end

  assign out_valid = ovld_r;

endmodule

// ===== hw/rtl/euv_checker.sv =====
// euv_checker: port-level assertions for equirect_uv_triangle
// depends on the top level's ports only; bound below
module euv_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [17:0] out_u_a,
  input logic [16:0] out_v_a,
  input logic [17:0] out_u_b,
  input logic [16:0] out_v_b,
  input logic [17:0] out_u_c,
  input logic [16:0] out_v_c,
  input logic        out_degenerate
);

  // a stalled result stays valid and keeps out_u_a and out_v_c stable
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_u_a) && $stable(out_v_c))
    else $error("stalled result changed");

  // input stalls only behind a stalled full output
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stall without output back-pressure");

  // degenerate triangle carries zero coordinates
  a_degen: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |-> out_u_a == '0 && out_u_b == '0 && out_u_c == '0
      && out_v_a == '0 && out_v_b == '0 && out_v_c == '0)
    else $error("degenerate result with nonzero uv");

  // reset empties the output
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind equirect_uv_triangle euv_checker u_euv_checker (
  .clk(clk), .rst_n(rst_n), .in_stall(in_stall), .out_valid(out_valid),
  .out_stall(out_stall), .out_u_a(out_u_a), .out_v_a(out_v_a), .out_u_b(out_u_b),
  .out_v_b(out_v_b), .out_u_c(out_u_c), .out_v_c(out_v_c),
  .out_degenerate(out_degenerate)
);

// ===== tb/equirect_uv_triangle_tb.sv =====
// equirect_uv_triangle_tb: self-checking testbench for the equirectangular uv block
// depends on euv_pkg and equirect_uv_triangle; predicts each triangle's uv in fixed point
`timescale 1ns / 100ps

module equirect_uv_triangle_tb;

  localparam int CB = 16;
  localparam int LATENCY = 2 * 16 + 6;

  typedef struct packed {
    logic [17:0] u_a;
    logic [16:0] v_a;
    logic [17:0] u_b;
    logic [16:0] v_b;
    logic [17:0] u_c;
    logic [16:0] v_c;
    logic        degenerate;
  } uv_result_t;

  typedef logic signed [CB-1:0] coord9_t [9];

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic signed [CB-1:0] in_ax, in_ay, in_az, in_bx, in_by_coord, in_bz, in_cx, in_cy, in_cz;
  logic out_valid;
  logic out_stall;
  logic [17:0] out_u_a, out_u_b, out_u_c;
  logic [16:0] out_v_a, out_v_b, out_v_c;
  logic out_degenerate;
  logic cfg_valid;
  logic cfg_ready;
  logic [1:0] cfg_index;
  logic [16:0] cfg_data;

  // predictor copy of the threshold registers
  longint seam_thr;
  longint low_thr;

  uv_result_t uv_expected[$];
  int error_count;
  bit sender_idle_ok;
  bit sink_idle_ok;

  equirect_uv_triangle dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_ax(in_ax), .in_ay(in_ay), .in_az(in_az),
    .in_bx(in_bx), .in_by_coord(in_by_coord), .in_bz(in_bz),
    .in_cx(in_cx), .in_cy(in_cy), .in_cz(in_cz),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_u_a(out_u_a), .out_v_a(out_v_a),
    .out_u_b(out_u_b), .out_v_b(out_v_b),
    .out_u_c(out_u_c), .out_v_c(out_v_c),
    .out_degenerate(out_degenerate),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit
  initial begin
    #4000000;
    $display("status: fail");
    $finish;
  end

  // floor shift for signed values
  function automatic longint shr_floor(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint arctan_step(int i);
    longint t;
    t = longint'(euv_pkg::atan_turns(i));
    return t;
  endfunction

  // cordic vectoring, returns accumulated angle and updates x, y
  function automatic longint rotate_to_axis(inout longint x, inout longint y);
    longint a, dx, dy;
    a = 0;
    for (int i = 0; i < 16; i++) begin
      dx = shr_floor(y, i);
      dy = shr_floor(x, i);
      if (y >= 0) begin
        x += dx; y -= dy; a += arctan_step(i);
      end else begin
        x -= dx; y += dy; a -= arctan_step(i);
      end
    end
    return a;
  endfunction

  // atan2(py, px) in turns scaled by 2^32, clamped to a half turn
  function automatic longint turns_atan2(longint px, longint py);
    longint half, a, b;
    half = 64'sd1 << 31;
    b = 0;
    if (py == 0) return (px < 0) ? half : 0;
    if (px == 0) return (py > 0) ? (64'sd1 << 30) : -(64'sd1 << 30);
    if (px < 0) begin
      b = (py > 0) ? half : -half;
      px = -px;
      py = -py;
    end
    a = b + rotate_to_axis(px, py);
    if (a > half) a = half;
    if (a < -half) a = -half;
    return a;
  endfunction

  function automatic longint turns_to_frac(longint full);
    return (full + (64'sd1 << 15)) >>> 16;
  endfunction

  function automatic void wrap_seam(inout longint first, inout longint second);
    longint d;
    d = first - second;
    if (d < 0) d = -d;
    if (d > seam_thr) begin
      if (first < low_thr) first += 64'sd1 << 16;
      else second += 64'sd1 << 16;
    end
  endfunction

  // expected uv for one triangle
  function automatic uv_result_t triangle_uv(coord9_t c);
    longint w[9];
    longint u[3], v[3];
    longint mx, mz, r, a;
    bit degen;
    uv_result_t res;
    degen = 0;
    for (int k = 0; k < 9; k++) w[k] = longint'(c[k]) * (64'sd1 << 18);
    for (int k = 0; k < 3; k++) begin
      u[k] = 0; v[k] = 0;
      if (w[3*k] == 0 && w[3*k+1] == 0 && w[3*k+2] == 0) degen = 1;
    end
    if (!degen) begin
      for (int k = 0; k < 3; k++) begin
        mx = (w[3*k] < 0) ? -w[3*k] : w[3*k];
        mz = w[3*k+2];
        void'(rotate_to_axis(mx, mz));
        r = (mx * longint'(euv_pkg::KINV_Q24) + (64'sd1 << 23)) >>> 24;
        u[k] = turns_to_frac(turns_atan2(w[3*k], w[3*k+2]) + (64'sd1 << 31));
        a = turns_atan2(w[3*k+1], r);
        if (a < 0) a = 0;
        v[k] = turns_to_frac(2 * a);
      end
      wrap_seam(u[0], u[1]);
      wrap_seam(u[0], u[2]);
      wrap_seam(u[1], u[2]);
    end
    res.u_a = u[0][17:0]; res.v_a = v[0][16:0];
    res.u_b = u[1][17:0]; res.v_b = v[1][16:0];
    res.u_c = u[2][17:0]; res.v_c = v[2][16:0];
    res.degenerate = degen;
    return res;
  endfunction

  // send one triangle, predict on acceptance
  task automatic send_triangle(coord9_t c);
    int gap;
    if (sender_idle_ok && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_ax <= c[0]; in_ay <= c[1]; in_az <= c[2];
    in_bx <= c[3]; in_by_coord <= c[4]; in_bz <= c[5];
    in_cx <= c[6]; in_cy <= c[7]; in_cz <= c[8];
    do @(posedge clk); while (in_stall);
    uv_expected.insert(uv_expected.size(), triangle_uv(c));
  endtask

  task automatic stop_sending();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain_results();
    while (uv_expected.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic write_register(euv_pkg::cfg_idx_t idx, logic [16:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == euv_pkg::CFG_SEAM) seam_thr = val;
    else low_thr = val;
    @(posedge clk);
  endtask

  function automatic coord9_t random_triangle();
    coord9_t c;
    int sel;
    for (int k = 0; k < 9; k++) begin
      sel = $urandom_range(0, 15);
      if (sel == 0) c[k] = 16'sh0000;
      else if (sel == 1) c[k] = 16'sh7FFF;
      else if (sel == 2) c[k] = 16'sh8000;
      else if (sel < 6) c[k] = CB'($urandom_range(0, 64)) - 16'sd32;
      else c[k] = CB'($urandom);
    end
    return c;
  endfunction

  function automatic coord9_t vertex_set(int a0, int a1, int a2, int b0, int b1, int b2,
                                        int c0, int c1, int c2);
    coord9_t c;
    c[0] = CB'(a0); c[1] = CB'(a1); c[2] = CB'(a2);
    c[3] = CB'(b0); c[4] = CB'(b1); c[5] = CB'(b2);
    c[6] = CB'(c0); c[7] = CB'(c1); c[8] = CB'(c2);
    return c;
  endfunction

  // result checker on the output side
  always @(posedge clk) begin
    uv_result_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_u_a, out_v_a, out_u_b, out_v_b, out_u_c, out_v_c, out_degenerate};
      if (uv_expected.size() == 0) begin
        $error("unexpected transaction u_a=%0d", got.u_a);
        error_count++;
      end else begin
        want = uv_expected.pop_front();
        if (got.u_a != want.u_a) begin
          $error("u_a expected %0d actual %0d", want.u_a, got.u_a); error_count++;
        end
        if (got.v_a != want.v_a) begin
          $error("v_a expected %0d actual %0d", want.v_a, got.v_a); error_count++;
        end
        if (got.u_b != want.u_b) begin
          $error("u_b expected %0d actual %0d", want.u_b, got.u_b); error_count++;
        end
        if (got.v_b != want.v_b) begin
          $error("v_b expected %0d actual %0d", want.v_b, got.v_b); error_count++;
        end
        if (got.u_c != want.u_c) begin
          $error("u_c expected %0d actual %0d", want.u_c, got.u_c); error_count++;
        end
        if (got.v_c != want.v_c) begin
          $error("v_c expected %0d actual %0d", want.v_c, got.v_c); error_count++;
        end
        if (got.degenerate != want.degenerate) begin
          $error("degenerate expected %0d actual %0d", want.degenerate, got.degenerate);
          error_count++;
        end
      end
    end
  end

  // output stall bursts
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (sink_idle_ok && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 9)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // axes, extremes, zero vertex and seam cases at reset thresholds
  task automatic test_directed();
    send_triangle(vertex_set(100, 0, 0, -100, 0, 0, 0, 0, 100));
    send_triangle(vertex_set(0, 0, -100, 0, 100, 0, 0, -100, 0));
    send_triangle(vertex_set(0, 0, 0, 5, 5, 5, 7, 7, 7));
    send_triangle(vertex_set(1, 1, 1, 0, 0, 0, 7, 7, 7));
    send_triangle(vertex_set(1, 1, 1, 2, 2, 2, 0, 0, 0));
    send_triangle(vertex_set(32767, 32767, 32767, -32768, -32768, -32768,
                             32767, -32768, 32767));
    send_triangle(vertex_set(-32768, 0, 1, -32768, 0, -1, -32768, 5, 0));
    send_triangle(vertex_set(-1000, 10, 10, -1000, 10, -10, 1000, 10, 0));
    send_triangle(vertex_set(-32768, -32768, 0, 32767, 32767, 0, 0, -32768, 0));
    send_triangle(vertex_set(1, -1, 1, -1, 1, -1, 1, 1, -1));
    send_triangle(vertex_set(-16384, 3, 1, -16384, 3, -1, -16384, 3, 2));
    stop_sending();
  endtask

  // thresholds at extremes with seam-crossing triangles
  task automatic test_config_extremes();
    logic [16:0] seam_vals[4] = '{17'd0, 17'd65536, 17'd1, 17'd32768};
    logic [16:0] low_vals[4] = '{17'd65536, 17'd0, 17'd40000, 17'd1};
    for (int p = 0; p < 4; p++) begin
      drain_results();
      write_register(euv_pkg::CFG_SEAM, seam_vals[p]);
      write_register(euv_pkg::CFG_LOW, low_vals[p]);
      send_triangle(vertex_set(-1000, 10, 10, -1000, 10, -10, 1000, 10, 0));
      send_triangle(vertex_set(-1000, 10, -10, -1000, 10, 10, 5, 3, 900));
      for (int n = 0; n < 40; n++) send_triangle(random_triangle());
      stop_sending();
    end
    drain_results();
    write_register(euv_pkg::CFG_SEAM, 17'd45875);
    write_register(euv_pkg::CFG_LOW, 17'd19661);
  endtask

  // random triangles with a pause to empty the pipeline midway, then no gaps or stalls at the end
  task automatic test_random_stream();
    for (int n = 0; n < 1220; n++) begin
      if (n == 500) begin
        stop_sending();
        while (uv_expected.size() != 0) @(posedge clk);
      end
      if (n == 1070) begin
        sender_idle_ok = 0;
        sink_idle_ok = 0;
      end
      send_triangle(random_triangle());
    end
    stop_sending();
  endtask

  initial begin
    error_count = 0;
    sender_idle_ok = 1;
    sink_idle_ok = 1;
    seam_thr = 45875;
    low_thr = 19661;
    rst_n = 1'b0;
    in_valid = 1'b0;
    {in_ax, in_ay, in_az, in_bx, in_by_coord, in_bz, in_cx, in_cy, in_cz} = '0;
    cfg_valid = 1'b0;
    cfg_index = euv_pkg::CFG_SEAM;
    cfg_data = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_config_extremes();
    test_random_stream();
    while (uv_expected.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/euv_pkg.sv
hw/rtl/euv_cordic_cell.sv
hw/rtl/euv_vertex.sv
hw/rtl/equirect_uv_triangle.sv
hw/rtl/euv_checker.sv
tb/equirect_uv_triangle_tb.sv
